### rtl/lmed_pkg.sv
// Shared types, codes and constants for the list-mode event stream decoder.
// Used by the parser, the result queue and the top level; no dependencies.
package lmed_pkg;

   localparam int PIXELS_PER_TUBE = 1024;
   localparam int POS_BITS        = $clog2(PIXELS_PER_TUBE);

   localparam int BYTE_W  = 8;
   localparam int KIND_W  = 3;
   localparam int PIXEL_W = 24;
   localparam int TIME_W  = 49;
   localparam int TS_W    = 48;
   localparam int CHAN_W  = 3;
   localparam int TUBE_W  = 8;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 8;

   // result kinds
   localparam logic [KIND_W-1:0] KIND_NEUTRON   = 3'd0;
   localparam logic [KIND_W-1:0] KIND_CHOPPER   = 3'd1;
   localparam logic [KIND_W-1:0] KIND_INTEGRITY = 3'd2;
   localparam logic [KIND_W-1:0] KIND_RANGE     = 3'd3;
   localparam logic [KIND_W-1:0] KIND_END       = 3'd4;

   // parse phases
   localparam logic [2:0] PH_START  = 3'd0;
   localparam logic [2:0] PH_HEADER = 3'd1;
   localparam logic [2:0] PH_EVENTS = 3'd2;
   localparam logic [2:0] PH_SEP    = 3'd3;
   localparam logic [2:0] PH_ENDED  = 3'd4;
   localparam logic [2:0] PH_ERROR  = 3'd5;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_CHOPPER_CHANNEL = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_TUBE_COUNT      = 1'b1;

   localparam logic [BYTE_W-1:0] END_OF_LIST_BYTE = 8'hFF;
   localparam logic [5:0]  HDR_LAST_IDX    = 6'd41;
   localparam logic [15:0] HDR_WORDS       = 16'd21;
   // ceil(2^17/3): (x * DIV3_RECIP) >> 17 equals x/3 for any 16-bit x
   localparam logic [16:0] DIV3_RECIP      = 17'd43691;
   localparam logic [2:0]  TRIG_ID_CHOPPER = 3'd7;

   typedef struct packed {
      logic [KIND_W-1:0]  kind;
      logic [PIXEL_W-1:0] pixel_index;
      logic [TIME_W-1:0]  event_time;
   } result_type;

   function automatic logic [BYTE_W-1:0] sep_byte(input logic [2:0] idx);
      logic [BYTE_W-1:0] b;
      unique case (idx)
         3'd0, 3'd1: b = 8'h00;
         3'd2, 3'd3: b = 8'hFF;
         3'd4, 3'd5: b = 8'h55;
         3'd6, 3'd7: b = 8'hAA;
      endcase
      return b;
   endfunction

endpackage

### rtl/lmed_parser.sv
// Byte-serial parser: header capture, event assembly and decode, separator check.
// Depends on lmed_pkg.
module lmed_parser
   import lmed_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                byte_valid,
   input  logic [BYTE_W-1:0]   stream_byte,
   input  logic [CHAN_W-1:0]   chopper_channel,
   input  logic [TUBE_W-1:0]   tube_count,
   output logic                res_valid,
   output result_type          res
);

   logic [2:0]        phase_ff, phase_in;
   logic [5:0]        hcount_ff, hcount_in;
   logic [15:0]       length_ff, length_in;
   logic [7:0]        device_ff, device_in;
   logic [TS_W-1:0]   stamp_ff, stamp_in;
   logic [14:0]       left_ff, left_in;
   logic [2:0]        ecount_ff, ecount_in;
   logic [47:0]       eword_ff, eword_in;
   logic [2:0]        sepidx_ff, sepidx_in;
   logic [7:0]        high_ff, high_in;

   logic [15:0]       word;
   logic              hdr_active;
   logic [5:0]        hdr_idx;
   logic [15:0]       len_diff;
   logic [31:0]       quot_prod;
   logic [14:0]       quotient;
   logic [47:0]       w;
   logic [TIME_W-1:0] t;
   logic [13:0]       pix_hi;
   logic [14:0]       left_dec;

   assign word       = {high_ff, stream_byte};
   assign hdr_active = (phase_ff == PH_HEADER) ||
                       ((phase_ff == PH_START) && (stream_byte != END_OF_LIST_BYTE));
   assign hdr_idx    = (phase_ff == PH_START) ? 6'd0 : hcount_ff;
   assign len_diff   = length_ff - HDR_WORDS;
   assign quot_prod  = {16'd0, len_diff} * {15'd0, DIV3_RECIP};
   assign quotient   = quot_prod[31:17];
   assign w          = {word, eword_ff[31:0]};
   assign t          = {1'b0, stamp_ff} + {30'd0, w[18:0]};
   assign pix_hi     = {device_ff, 6'd0} | {8'd0, w[46:44], 3'd0} | {9'd0, w[43:39]};
   assign left_dec   = left_ff - 15'd1;

   always_comb begin
      phase_in  = phase_ff;
      hcount_in = hcount_ff;
      length_in = length_ff;
      device_in = device_ff;
      stamp_in  = stamp_ff;
      left_in   = left_ff;
      ecount_in = ecount_ff;
      eword_in  = eword_ff;
      sepidx_in = sepidx_ff;
      high_in   = high_ff;
      res_valid = 1'b0;
      res       = '0;

      if (byte_valid) begin
         if (hdr_active) begin
            if (!hdr_idx[0]) begin
               high_in = stream_byte;
            end else begin
               case (hdr_idx)
                  6'd1:    length_in = word;
                  6'd13:   stamp_in[15:0]  = word;
                  6'd15:   stamp_in[31:16] = word;
                  6'd17:   stamp_in[47:32] = word;
                  default: ;
               endcase
            end
            if (hdr_idx == 6'd10) begin
               device_in = stream_byte;
            end
            if (hdr_idx >= HDR_LAST_IDX) begin
               hcount_in = 6'd0;
               left_in   = quotient;
               ecount_in = 3'd0;
               if (quotient != 15'd0) begin
                  phase_in = PH_EVENTS;
               end else begin
                  phase_in  = PH_SEP;
                  sepidx_in = 3'd0;
               end
            end else begin
               hcount_in = hdr_idx + 6'd1;
               phase_in  = PH_HEADER;
            end
         end else begin
            unique case (phase_ff)
               PH_START: begin
                  // end-of-list marker
                  res_valid = 1'b1;
                  res.kind  = KIND_END;
                  phase_in  = PH_ENDED;
               end
               PH_EVENTS: begin
                  if (!ecount_ff[0]) begin
                     high_in = stream_byte;
                  end else begin
                     case (ecount_ff)
                        3'd1:    eword_in[15:0]  = word;
                        3'd3:    eword_in[31:16] = word;
                        default: eword_in[47:32] = word;
                     endcase
                  end
                  if (ecount_ff >= 3'd5) begin
                     if (w[47]) begin
                        // trigger: only the chopper channel with id 7 is kept
                        if ((chopper_channel != '0) &&
                            (w[43:40] == ({1'b0, chopper_channel} - 4'd1)) &&
                            (w[46:44] == TRIG_ID_CHOPPER)) begin
                           res_valid      = 1'b1;
                           res.kind       = KIND_CHOPPER;
                           res.event_time = t;
                        end
                     end else begin
                        res_valid       = 1'b1;
                        res.kind        = (pix_hi < {6'd0, tube_count}) ? KIND_NEUTRON
                                                                        : KIND_RANGE;
                        res.pixel_index = {pix_hi, w[28:19]};
                        res.event_time  = t;
                     end
                     ecount_in = 3'd0;
                     left_in   = left_dec;
                     if (left_dec == 15'd0) begin
                        phase_in  = PH_SEP;
                        sepidx_in = 3'd0;
                     end
                  end else begin
                     ecount_in = ecount_ff + 3'd1;
                  end
               end
               PH_SEP: begin
                  if (stream_byte != sep_byte(sepidx_ff)) begin
                     res_valid = 1'b1;
                     res.kind  = KIND_INTEGRITY;
                     phase_in  = PH_ERROR;
                  end else if (sepidx_ff == 3'd7) begin
                     sepidx_in = 3'd0;
                     phase_in  = PH_START;
                  end else begin
                     sepidx_in = sepidx_ff + 3'd1;
                  end
               end
               default: ;  // ended or error: drop the byte
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_START;
         hcount_ff <= '0;
         length_ff <= '0;
         device_ff <= '0;
         stamp_ff  <= '0;
         left_ff   <= '0;
         ecount_ff <= '0;
         eword_ff  <= '0;
         sepidx_ff <= '0;
         high_ff   <= '0;
      end else begin
         phase_ff  <= phase_in;
         hcount_ff <= hcount_in;
         length_ff <= length_in;
         device_ff <= device_in;
         stamp_ff  <= stamp_in;
         left_ff   <= left_in;
         ecount_ff <= ecount_in;
         eword_ff  <= eword_in;
         sepidx_ff <= sepidx_in;
         high_ff   <= high_in;
      end
   end

endmodule

### rtl/lmed_out_queue.sv
// Result register with a skid stage; the parser keeps taking bytes until it fills.
// Depends on lmed_pkg.
module lmed_out_queue
   import lmed_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   input  result_type  push_data,
   output logic        full,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output result_type  rsp_data
);

   logic        main_valid_ff, main_valid_in;
   logic        skid_valid_ff, skid_valid_in;
   result_type  main_ff, main_in;
   result_type  skid_ff, skid_in;
   logic        pop;

   assign pop       = main_valid_ff && !rsp_stall;
   assign full      = skid_valid_ff;
   assign rsp_valid = main_valid_ff;
   assign rsp_data  = main_ff;

   always_comb begin
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      main_in       = main_ff;
      skid_in       = skid_ff;
      if (skid_valid_ff) begin
         // advance the skid entry once the head transfer completes
         if (pop) begin
            main_in       = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else if (push) begin
         if (!main_valid_ff || pop) begin
            main_in       = push_data;
            main_valid_in = 1'b1;
         end else begin
            skid_in       = push_data;
            skid_valid_in = 1'b1;
         end
      end else if (pop) begin
         main_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

   a_skid_needs_head: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> main_valid_ff)
      else $error("skid entry held without a head entry");

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> !push)
      else $error("result pushed while skid stage is occupied");

   a_skid_drains: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff && !rsp_stall |=> main_valid_ff && !skid_valid_ff)
      else $error("skid entry did not advance after head transfer");

   a_overflow_to_skid: assert property (@(posedge clock) disable iff (reset)
      push && main_valid_ff && rsp_stall |=> skid_valid_ff)
      else $error("result lost under output stall");

endmodule

### rtl/listmode_event_stream_decoder_core.sv
// Top level of the list-mode event stream decoder: configuration registers,
// byte parser and result queue. Depends on lmed_pkg, lmed_parser, lmed_out_queue.
//
// Takes one stream byte per cycle and gives at most one result per byte, registered
// in a result register backed by one skid entry. Throughput is one byte per clock;
// the only stall on the input comes from the result side holding stall while both
// result entries are full. Every header, event and separator byte is handled in
// the cycle it is taken, with the event count derived by a reciprocal multiply at
// the last header byte.
module listmode_event_stream_decoder_core
   import lmed_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [BYTE_W-1:0]     req_stream_byte,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [KIND_W-1:0]     rsp_kind,
   output logic [PIXEL_W-1:0]    rsp_pixel_index,
   output logic [TIME_W-1:0]     rsp_event_time,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   logic [CHAN_W-1:0] chopper_ff, chopper_in;
   logic [TUBE_W-1:0] tubes_ff, tubes_in;
   logic              accept;
   logic              res_valid;
   result_type        res;
   result_type        rsp_data;
   logic              queue_full;

   always_comb begin
      chopper_in = chopper_ff;
      tubes_in   = tubes_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_CHOPPER_CHANNEL: chopper_in = csr_wdata[CHAN_W-1:0];
            CSR_TUBE_COUNT:      tubes_in   = csr_wdata[TUBE_W-1:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chopper_ff <= 3'd2;
         tubes_ff   <= 8'd128;
      end else begin
         chopper_ff <= chopper_in;
         tubes_ff   <= tubes_in;
      end
   end

   assign req_stall = queue_full;
   assign accept    = req_valid && !queue_full;

   lmed_parser u_parser (
      .clock           (clock),
      .reset           (reset),
      .byte_valid      (accept),
      .stream_byte     (req_stream_byte),
      .chopper_channel (chopper_ff),
      .tube_count      (tubes_ff),
      .res_valid       (res_valid),
      .res             (res)
   );

   lmed_out_queue u_out_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (res_valid),
      .push_data (res),
      .full      (queue_full),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   assign rsp_kind        = rsp_data.kind;
   assign rsp_pixel_index = rsp_data.pixel_index;
   assign rsp_event_time  = rsp_data.event_time;

endmodule

### dv/lmed_stream_checker.sv
// Scoreboard for the list-mode event stream decoder: tracks byte and CSR transfers,
// predicts each result and compares it with the result channel. Depends on lmed_pkg.
module lmed_stream_checker
   import lmed_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_stall,
   input  logic [BYTE_W-1:0]     req_stream_byte,
   input  logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  logic [KIND_W-1:0]     rsp_kind,
   input  logic [PIXEL_W-1:0]    rsp_pixel_index,
   input  logic [TIME_W-1:0]     rsp_event_time,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output int                    mismatch_count,
   output int                    pending_results
);
   timeunit 1ns;
   timeprecision 1ps;

   // header byte positions (odd ones close a 16-bit word)
   localparam logic [5:0] LEN_LO_IDX = 6'd1;
   localparam logic [5:0] DEV_IDX    = 6'd10;
   localparam logic [5:0] TS_LO_IDX  = 6'd13;
   localparam logic [5:0] TS_MID_IDX = 6'd15;
   localparam logic [5:0] TS_HI_IDX  = 6'd17;
   localparam logic [63:0] SEP_SEQ   = 64'h0000_FFFF_5555_AAAA;

   logic [CHAN_W-1:0] cfg_chan;
   logic [TUBE_W-1:0] cfg_tubes;

   logic [2:0]      phase;
   logic [5:0]      hdr_cnt;
   logic [15:0]     buf_len;
   logic [7:0]      dev_id;
   logic [TS_W-1:0] buf_ts;
   logic [14:0]     evt_left;
   logic [2:0]      evt_cnt;
   logic [47:0]     evt_word;
   logic [2:0]      sep_idx;
   logic [7:0]      hi_byte;

   result_type expected_results[$];

   // append one predicted result at the tail
   function automatic void queue_result(input result_type r);
      expected_results.insert(expected_results.size(), r);
   endfunction

   always @(posedge clock) begin : track
      logic [BYTE_W-1:0]  b;
      logic [15:0]        word;
      logic [15:0]        quot;
      logic [TIME_W-1:0]  t;
      logic [13:0]        tube_id;
      logic [PIXEL_W-1:0] pix;
      logic [3:0]         chop_data_chan;
      result_type         pred;
      result_type         want;

      if (reset) begin
         cfg_chan  = 3'd2;
         cfg_tubes = 8'd128;
         phase     = PH_START;
         hdr_cnt   = '0;
         buf_len   = '0;
         dev_id    = '0;
         buf_ts    = '0;
         evt_left  = '0;
         evt_cnt   = '0;
         evt_word  = '0;
         sep_idx   = '0;
         hi_byte   = '0;
         expected_results.delete();
      end else begin
         // compare before predicting so a result never matches a prediction from this cycle's byte
         if (rsp_valid && !rsp_stall) begin
            if (expected_results.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("%0t: unexpected result kind %0d pixel %0h time %0h", $realtime,
                           rsp_kind, rsp_pixel_index, rsp_event_time);
            end else begin
               want = expected_results.pop_front();
               if (want.kind !== rsp_kind || want.pixel_index !== rsp_pixel_index ||
                   want.event_time !== rsp_event_time) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display("%0t: expected %0d/%0h/%0h, got %0d/%0h/%0h",
                              $realtime, want.kind, want.pixel_index, want.event_time,
                              rsp_kind, rsp_pixel_index, rsp_event_time);
               end
            end
         end

         if (csr_wr_en) begin
            case (csr_index)
               CSR_CHOPPER_CHANNEL: cfg_chan  = csr_wdata[CHAN_W-1:0];
               CSR_TUBE_COUNT:      cfg_tubes = csr_wdata[TUBE_W-1:0];
               default: ;
            endcase
         end

         if (req_valid && !req_stall) begin
            b    = req_stream_byte;
            word = {hi_byte, b};

            if (phase == PH_START) begin
               if (b == END_OF_LIST_BYTE) begin
                  pred      = '0;
                  pred.kind = KIND_END;
                  queue_result(pred);
                  phase = PH_ENDED;
               end else begin
                  // open a new buffer; this byte is header byte zero
                  phase   = PH_HEADER;
                  hdr_cnt = '0;
               end
            end

            case (phase)
               PH_HEADER: begin
                  if (!hdr_cnt[0]) begin
                     hi_byte = b;
                  end else begin
                     case (hdr_cnt)
                        LEN_LO_IDX: buf_len       = word;
                        TS_LO_IDX:  buf_ts[15:0]  = word;
                        TS_MID_IDX: buf_ts[31:16] = word;
                        TS_HI_IDX:  buf_ts[47:32] = word;
                        default: ;
                     endcase
                  end
                  if (hdr_cnt == DEV_IDX)
                     dev_id = b;
                  if (hdr_cnt >= HDR_LAST_IDX) begin
                     hdr_cnt  = '0;
                     quot     = (buf_len - HDR_WORDS) / 16'd3;
                     evt_left = quot[14:0];
                     evt_cnt  = '0;
                     if (evt_left != 0) begin
                        phase = PH_EVENTS;
                     end else begin
                        sep_idx = '0;
                        phase   = PH_SEP;
                     end
                  end else begin
                     hdr_cnt = hdr_cnt + 6'd1;
                  end
               end

               PH_EVENTS: begin
                  if (!evt_cnt[0]) begin
                     hi_byte = b;
                  end else begin
                     case (evt_cnt[2:1])
                        2'd0: evt_word[15:0]  = word;
                        2'd1: evt_word[31:16] = word;
                        default: evt_word[47:32] = word;
                     endcase
                  end
                  if (evt_cnt >= 3'd5) begin
                     t = {1'b0, buf_ts} + {30'd0, evt_word[18:0]};
                     if (evt_word[47]) begin
                        chop_data_chan = {1'b0, cfg_chan} - 4'd1;
                        // channel zero never matches; other triggers are dropped
                        if (cfg_chan != 0 && evt_word[43:40] == chop_data_chan &&
                            evt_word[46:44] == TRIG_ID_CHOPPER) begin
                           pred            = '0;
                           pred.kind       = KIND_CHOPPER;
                           pred.event_time = t;
                           queue_result(pred);
                        end
                     end else begin
                        tube_id = {dev_id, 6'd0} | {8'd0, evt_word[46:44], 3'd0} |
                                  {9'd0, evt_word[43:39]};
                        pix     = {tube_id, evt_word[28:19]};
                        pred             = '0;
                        pred.kind        = (pix < {cfg_tubes, 10'd0}) ? KIND_NEUTRON : KIND_RANGE;
                        pred.pixel_index = pix;
                        pred.event_time  = t;
                        queue_result(pred);
                     end
                     evt_cnt  = '0;
                     evt_left = evt_left - 15'd1;
                     if (evt_left == 0) begin
                        sep_idx = '0;
                        phase   = PH_SEP;
                     end
                  end else begin
                     evt_cnt = evt_cnt + 3'd1;
                  end
               end

               PH_SEP: begin
                  if (b != SEP_SEQ[63 - 8*sep_idx -: 8]) begin
                     pred      = '0;
                     pred.kind = KIND_INTEGRITY;
                     queue_result(pred);
                     phase = PH_ERROR;
                  end else if (sep_idx == 3'd7) begin
                     sep_idx = '0;
                     phase   = PH_START;
                  end else begin
                     sep_idx = sep_idx + 3'd1;
                  end
               end

               default: ;
            endcase
         end
      end
      pending_results = expected_results.size();
   end

endmodule

### dv/tb.sv
// Top of the list-mode event stream decoder testbench: clock, reset, byte stream,
// CSR writes and result-side stalls. Depends on lmed_pkg, the decoder and lmed_stream_checker.
module tb
   import lmed_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [BYTE_W-1:0]     req_stream_byte = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [KIND_W-1:0]     rsp_kind;
   logic [PIXEL_W-1:0]    rsp_pixel_index;
   logic [TIME_W-1:0]     rsp_event_time;
   logic                  csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   int                mismatch_count;
   int                pending_results;
   int                bytes_sent = 0;
   bit                sender_calm = 1'b0;
   logic [CHAN_W-1:0] cur_chan = 3'd2;

   listmode_event_stream_decoder_core u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_stream_byte (req_stream_byte),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_kind        (rsp_kind),
      .rsp_pixel_index (rsp_pixel_index),
      .rsp_event_time  (rsp_event_time),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   lmed_stream_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_stream_byte (req_stream_byte),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_kind        (rsp_kind),
      .rsp_pixel_index (rsp_pixel_index),
      .rsp_event_time  (rsp_event_time),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .mismatch_count  (mismatch_count),
      .pending_results (pending_results)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   initial begin
      #2_000_000;
      $display("Mismatches found");
      $finish;
   end

   // result-side stalls: short bursts, a few long ones, and stall-free stretches
   always @(negedge clock) begin : rsp_stall_gen
      int stall_left;
      int r;
      if (stall_left > 0) begin
         stall_left--;
      end else begin
         r = $urandom_range(0, 99);
         if (r < 4) begin
            rsp_stall  = 1'b0;
            stall_left = $urandom_range(50, 200);
         end else if (r < 60) begin
            rsp_stall  = 1'b0;
            stall_left = $urandom_range(0, 3);
         end else if (r < 95) begin
            rsp_stall  = 1'b1;
            stall_left = $urandom_range(0, 2);
         end else begin
            rsp_stall  = 1'b1;
            stall_left = $urandom_range(10, 40);
         end
      end
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (sender_calm || r < 70)
         return 0;
      if (r < 96)
         return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // random event word: neutrons, triggers aimed at the chopper channel, other triggers
   function automatic logic [47:0] random_event();
      logic [47:0] w;
      int r;
      w = {16'($urandom), $urandom};
      r = $urandom_range(0, 99);
      if (r < 45) begin
         w[47] = 1'b0;
      end else begin
         w[47] = 1'b1;
         if (r < 75) begin
            w[46:44] = TRIG_ID_CHOPPER;
            w[43:40] = {1'b0, cur_chan} - 4'd1;
         end
      end
      return w;
   endfunction

   // one transfer; valid drops after it unless the next call raises it in the same step
   task automatic send_byte(input logic [BYTE_W-1:0] b);
      repeat (pick_gap()) @(negedge clock);
      req_stream_byte = b;
      req_valid       = 1'b1;
      do @(posedge clock); while (req_stall);
      bytes_sent++;
      @(negedge clock);
      req_valid = 1'b0;
   endtask

   task automatic send_header(input int n_events, input int extra, input logic [7:0] dev,
                              input logic [TS_W-1:0] ts);
      logic [15:0] len;
      logic [7:0]  b;
      int          i;
      len = HDR_WORDS + 16'(3 * n_events + extra);
      for (i = 0; i < 42; i++) begin
         case (i)
            0:  b = len[15:8];
            1:  b = len[7:0];
            10: b = dev;
            12: b = ts[15:8];
            13: b = ts[7:0];
            14: b = ts[31:24];
            15: b = ts[23:16];
            16: b = ts[47:40];
            17: b = ts[39:32];
            default: b = 8'($urandom);
         endcase
         send_byte(b);
      end
   endtask

   task automatic send_event(input logic [47:0] w);
      send_byte(w[15:8]);
      send_byte(w[7:0]);
      send_byte(w[31:24]);
      send_byte(w[23:16]);
      send_byte(w[47:40]);
      send_byte(w[39:32]);
   endtask

   // corrupt one bit of byte bad_at; bad_at of 8 or more leaves the separator intact
   task automatic send_separator(input int bad_at);
      logic [7:0] b;
      int         i;
      for (i = 0; i < 8; i++) begin
         b = sep_byte(3'(i));
         if (i == bad_at)
            b = b ^ 8'(1 << $urandom_range(0, 7));
         send_byte(b);
      end
   endtask

   // wait out all results and the pipeline, then rewrite both registers
   task automatic set_config(input logic [7:0] chan, input logic [7:0] tubes);
      while (pending_results != 0) @(negedge clock);
      repeat (4) @(negedge clock);
      csr_wr_en = 1'b1;
      csr_index = CSR_CHOPPER_CHANNEL;
      csr_wdata = chan;
      @(negedge clock);
      csr_index = CSR_TUBE_COUNT;
      csr_wdata = tubes;
      @(negedge clock);
      csr_wr_en = 1'b0;
      cur_chan  = chan[CHAN_W-1:0];
   endtask

   initial begin : stimulus
      int          n;
      int          i;
      int          k;
      logic [7:0]  dev;
      logic [7:0]  tubes;

      repeat (10) @(negedge clock);
      reset = 1'b0;

      // reset configuration: chopper channel 2, 128 tubes
      send_header(0, 0, 8'h00, 48'h0);          // empty buffer, length exactly 21
      send_separator(8);
      send_header(0, 2, 8'hFF, '1);             // empty buffer, leftover words
      send_separator(8);
      send_header(5, 1, 8'h00, 48'hFFFF_FFFF_FFFF);
      send_event(48'h0000_0000_0000);           // pixel zero, time does not carry into bit 48
      send_event(48'h7FFF_FFFF_FFFF);           // all neutron fields high, time carries
      send_event({1'b1, TRIG_ID_CHOPPER, 4'd1, 40'h00_0007_FFFF});
      send_event({1'b1, 3'd6, 4'd1, 40'hFF_FFFF_FFFF});
      send_event({1'b1, TRIG_ID_CHOPPER, 4'd2, 40'h0});
      send_separator(8);

      // chopper disabled, no tubes: every neutron out of range
      set_config(8'h00, 8'h00);
      send_header(3, 0, 8'h01, {16'($urandom), $urandom});
      send_event({1'b1, TRIG_ID_CHOPPER, 4'hF, 40'h0});
      send_event({1'b1, TRIG_ID_CHOPPER, 4'h7, 40'h12_3456_789A});
      send_event(48'h0000_0000_0000);
      send_separator(8);

      set_config(8'h07, 8'hFF);
      send_header(3, 0, 8'hFF, {16'($urandom), $urandom});
      send_event(48'h0000_0000_0000);
      send_event({1'b1, TRIG_ID_CHOPPER, 4'd6, 40'hFF_FFFF_FFFF});
      send_event({1'b1, TRIG_ID_CHOPPER, 4'hF, 40'h0});
      send_separator(8);
      send_header(1, 0, 8'h00, '0);
      send_event(48'h7FFF_FFFF_FFFF);
      send_separator(8);

      // one tube: pixel 1023 in range, 1024 out
      set_config(8'h04, 8'h01);
      send_header(3, 0, 8'h00, {16'($urandom), $urandom});
      send_event({1'b0, 3'd0, 5'd0, 10'd0, 10'h3FF, 19'h0});
      send_event({1'b0, 3'd0, 5'd1, 10'd0, 10'h000, 19'h7FFFF});
      send_event({1'b1, TRIG_ID_CHOPPER, 4'd3, 40'h0});
      send_separator(8);

      while (bytes_sent < 1100) begin
         sender_calm = ($urandom_range(0, 5) == 0);
         if ($urandom_range(0, 3) == 0) begin
            k     = $urandom_range(0, 3);
            tubes = (k == 0) ? 8'($urandom) : (k == 1) ? 8'd128 : 8'($urandom_range(1, 8));
            set_config(($urandom_range(0, 2) == 0) ? 8'($urandom) : 8'($urandom_range(1, 4)),
                       tubes);
         end
         n   = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 20) : $urandom_range(0, 6);
         dev = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 3));
         send_header(n, $urandom_range(0, 2), dev, {16'($urandom), $urandom});
         for (i = 0; i < n; i++)
            send_event(random_event());
         send_separator(8);
      end

      // close the stream: end of list or a broken separator, then ignored bytes
      sender_calm = 1'b0;
      if ($urandom_range(0, 1) == 0) begin
         send_byte(END_OF_LIST_BYTE);
      end else begin
         n = $urandom_range(1, 4);
         send_header(n, 0, 8'($urandom_range(0, 3)), {16'($urandom), $urandom});
         for (i = 0; i < n; i++)
            send_event(random_event());
         send_separator($urandom_range(0, 7));
      end
      repeat (6) send_byte(8'($urandom));

      for (k = 0; k < 20000 && pending_results != 0; k++)
         @(negedge clock);
      repeat (8) @(negedge clock);

      if (mismatch_count == 0 && pending_results == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule

### filelist.f
rtl/lmed_pkg.sv
rtl/lmed_parser.sv
rtl/lmed_out_queue.sv
rtl/listmode_event_stream_decoder_core.sv
dv/lmed_stream_checker.sv
dv/tb.sv
